// ----- rtl/svpr_pkg.sv -----
// Shared types, constants and codes for the servo pose record/playback unit.
// Used by every module of the block but svpr_ram; depends on nothing else.
package svpr_pkg;

   localparam int POSE_SLOTS = 10;
   localparam int SLOT_CNT_W = $clog2(POSE_SLOTS + 1);
   localparam int SLOT_IDX_W = (POSE_SLOTS > 1) ? $clog2(POSE_SLOTS) : 1;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_IDX_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int POT_W    = 10;
   localparam int WIDE_W   = 12;
   localparam int NARROW_W = 5;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 4;
   localparam int PROD_W   = 32;

   localparam logic [WIDE_W-1:0]   WIDE_MIN   = 12'd2000;
   localparam logic [WIDE_W-1:0]   WIDE_CTR   = 12'd3000;
   localparam logic [NARROW_W-1:0] NARROW_MIN = 5'd8;
   localparam logic [NARROW_W-1:0] NARROW_CTR = 5'd12;
   // 2000 * 1025; 1023 * 1025 is one less than 2**20.
   localparam logic [PROD_W-1:0]   WIDE_RECIP = 32'd2050000;

   localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PLAYBACK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LINK     = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NONE   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SAVED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PLAYED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

   typedef struct packed {
      logic [POT_W-1:0] pot_one;
      logic [POT_W-1:0] pot_two;
      logic [POT_W-1:0] pot_three;
      logic [POT_W-1:0] pot_four;
      logic             mode_press;
      logic             save_press;
      logic             play_press;
   } svpr_req_type;

   typedef struct packed {
      logic [WIDE_W-1:0]   pulse_one;
      logic [WIDE_W-1:0]   pulse_two;
      logic [NARROW_W-1:0] pulse_three;
      logic [NARROW_W-1:0] pulse_four;
      logic [MODE_W-1:0]   current_mode;
      logic [STATUS_W-1:0] event_status;
      logic [COUNT_W-1:0]  saved_count;
   } svpr_rsp_type;

   typedef struct packed {
      logic [WIDE_W-1:0]   wide_one;
      logic [WIDE_W-1:0]   wide_two;
      logic [NARROW_W-1:0] narrow_one;
      logic [NARROW_W-1:0] narrow_two;
   } svpr_pose_type;

   typedef struct packed {
      svpr_pose_type pose;
      logic          mode_press;
      logic          save_press;
      logic          play_press;
   } svpr_cmd_type;

endpackage

// ----- rtl/svpr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module svpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/svpr_front.sv -----
// Front end: takes request beats, maps the pot readings to pulse values and
// hands commands to the queue. Depends on svpr_pkg.
module svpr_front
   import svpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  svpr_req_type req_data,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output svpr_cmd_type cmd_data
);

   logic              s1_valid_ff;
   logic              s1_valid_in;
   svpr_req_type      s1_req_ff;
   logic [PROD_W-1:0] prod_one_ff;
   logic [PROD_W-1:0] prod_two_ff;

   // The product estimate is floor(v*2000/1023) or one below; the compare
   // against the exact numerator fixes the last step.
   function automatic logic [WIDE_W-1:0] map_wide(logic [POT_W-1:0] v,
                                                  logic [PROD_W-1:0] prod);
      logic [20:0] num;
      logic [10:0] q;
      logic [11:0] qn;
      logic [21:0] lim;
      num = (21'(v) << 11) - (21'(v) << 5) - (21'(v) << 4);
      q   = prod[30:20];
      qn  = 12'(q) + 12'd1;
      lim = (22'(qn) << 10) - 22'(qn);
      if (22'(num) >= lim) begin
         q = q + 11'd1;
      end
      return WIDE_MIN + WIDE_W'(q);
   endfunction

   function automatic logic [NARROW_W-1:0] map_narrow(logic [POT_W-1:0] v);
      logic [12:0] num;
      logic [23:0] est;
      logic [3:0]  q;
      logic [4:0]  qn;
      logic [14:0] lim;
      num = 13'(v) << 3;
      est = (24'(num) << 10) + 24'(num);
      q   = est[23:20];
      qn  = 5'(q) + 5'd1;
      lim = (15'(qn) << 10) - 15'(qn);
      if (15'(num) >= lim) begin
         q = q + 4'd1;
      end
      return NARROW_MIN + NARROW_W'(q);
   endfunction

   assign req_ready   = !s1_valid_ff || cmd_ready;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff   <= req_data;
         prod_one_ff <= PROD_W'(req_data.pot_one) * WIDE_RECIP;
         prod_two_ff <= PROD_W'(req_data.pot_two) * WIDE_RECIP;
      end
   end

   always_comb begin
      cmd_data.pose.wide_one   = map_wide(s1_req_ff.pot_one, prod_one_ff);
      cmd_data.pose.wide_two   = map_wide(s1_req_ff.pot_two, prod_two_ff);
      cmd_data.pose.narrow_one = map_narrow(s1_req_ff.pot_three);
      cmd_data.pose.narrow_two = map_narrow(s1_req_ff.pot_four);
      cmd_data.mode_press      = s1_req_ff.mode_press;
      cmd_data.save_press      = s1_req_ff.save_press;
      cmd_data.play_press      = s1_req_ff.play_press;
   end

   assign cmd_valid = s1_valid_ff;

endmodule

// ----- rtl/svpr_fifo.sv -----
// Short command queue between the front end and the executing back end.
// Depends on svpr_pkg.
module svpr_fifo
   import svpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  svpr_cmd_type push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output svpr_cmd_type pop_data
);

   svpr_cmd_type         entries_ff [CMD_DEPTH];
   logic [CMD_IDX_W-1:0] wr_ptr_ff;
   logic [CMD_IDX_W-1:0] wr_ptr_in;
   logic [CMD_IDX_W-1:0] rd_ptr_ff;
   logic [CMD_IDX_W-1:0] rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff;
   logic [CMD_CNT_W-1:0] count_in;
   logic                 do_push;
   logic                 do_pop;

   function automatic logic [CMD_IDX_W-1:0] ptr_next(logic [CMD_IDX_W-1:0] p);
      return (p == CMD_IDX_W'(CMD_DEPTH - 1)) ? '0 : p + CMD_IDX_W'(1);
   endfunction

   assign push_ready = (count_ff != CMD_CNT_W'(CMD_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/svpr_back.sv -----
// Back end: mode, pending presses, pose store and the result register.
// Depends on svpr_pkg and svpr_ram.
module svpr_back
   import svpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  svpr_cmd_type cmd_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output svpr_rsp_type rsp_data
);

   typedef enum logic [1:0] {
      BK_RUN  = 2'b01,
      BK_LOAD = 2'b10
   } back_state_type;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [MODE_W-1:0]     mode_ff;
   logic [MODE_W-1:0]     mode_in;
   logic                  save_pend_ff;
   logic                  save_pend_in;
   logic                  play_pend_ff;
   logic                  play_pend_in;
   logic [SLOT_CNT_W-1:0] slot_count_ff;
   logic [SLOT_CNT_W-1:0] slot_count_in;
   logic [SLOT_CNT_W-1:0] play_slot_ff;
   logic [SLOT_CNT_W-1:0] play_slot_in;
   svpr_pose_type         pose_ff;
   svpr_pose_type         pose_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   svpr_rsp_type          rsp_data_ff;
   svpr_rsp_type          rsp_data_in;

   logic                  out_free;
   logic                  take;
   logic                  ram_we;
   logic [SLOT_IDX_W-1:0] ram_waddr;
   logic [SLOT_IDX_W-1:0] ram_raddr;
   svpr_pose_type         ram_rdata;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == BK_RUN) && out_free;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      logic                  save_p;
      logic                  play_p;
      logic                  load;
      logic [MODE_W-1:0]     mode_v;
      logic [SLOT_CNT_W-1:0] slot_v;
      logic [SLOT_CNT_W-1:0] idx;
      logic [STATUS_W-1:0]   status;

      state_in      = state_ff;
      mode_in       = mode_ff;
      save_pend_in  = save_pend_ff;
      play_pend_in  = play_pend_ff;
      slot_count_in = slot_count_ff;
      play_slot_in  = play_slot_ff;
      pose_in       = pose_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = SLOT_IDX_W'(slot_count_ff);
      ram_raddr     = '0;

      save_p = save_pend_ff || cmd_data.save_press;
      play_p = play_pend_ff || cmd_data.play_press;
      load   = 1'b0;
      mode_v = mode_ff;
      slot_v = play_slot_ff;
      idx    = '0;
      status = ST_NONE;

      unique case (state_ff)
         BK_RUN: begin
            if (take) begin
               if (cmd_data.mode_press) begin
                  unique case (mode_ff)
                     MODE_MANUAL:   mode_v = MODE_PLAYBACK;
                     MODE_PLAYBACK: mode_v = MODE_LINK;
                     default:       mode_v = MODE_MANUAL;
                  endcase
                  if (mode_v == MODE_PLAYBACK) begin
                     slot_v = '0;
                  end
               end

               priority if (mode_v == MODE_MANUAL) begin
                  pose_in = cmd_data.pose;
                  if (save_p) begin
                     save_p = 1'b0;
                     if (slot_count_ff >= SLOT_CNT_W'(POSE_SLOTS)) begin
                        status = ST_FULL;
                     end else begin
                        ram_we        = 1'b1;
                        slot_count_in = slot_count_ff + SLOT_CNT_W'(1);
                        status        = ST_SAVED;
                     end
                  end
               end else if (mode_v == MODE_PLAYBACK) begin
                  if (play_p) begin
                     play_p = 1'b0;
                     if (slot_count_ff == '0) begin
                        status = ST_EMPTY;
                     end else begin
                        // Wrap to the first slot once every stored pose was played.
                        idx       = (slot_v >= slot_count_ff) ? '0 : slot_v;
                        ram_raddr = SLOT_IDX_W'(idx);
                        slot_v    = idx + SLOT_CNT_W'(1);
                        load      = 1'b1;
                     end
                  end
               end else begin
                  status = ST_NONE;
               end

               mode_in      = mode_v;
               save_pend_in = save_p;
               play_pend_in = play_p;
               play_slot_in = slot_v;

               if (load) begin
                  state_in = BK_LOAD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{pulse_one:    pose_in.wide_one,
                                   pulse_two:    pose_in.wide_two,
                                   pulse_three:  pose_in.narrow_one,
                                   pulse_four:   pose_in.narrow_two,
                                   current_mode: mode_v,
                                   event_status: status,
                                   saved_count:  COUNT_W'(slot_count_in)};
               end
            end
         end
         BK_LOAD: begin
            // The result register is empty here: the command was taken only
            // when it was free, and nothing was written since.
            pose_in      = ram_rdata;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{pulse_one:    ram_rdata.wide_one,
                             pulse_two:    ram_rdata.wide_two,
                             pulse_three:  ram_rdata.narrow_one,
                             pulse_four:   ram_rdata.narrow_two,
                             current_mode: mode_ff,
                             event_status: ST_PLAYED,
                             saved_count:  COUNT_W'(slot_count_ff)};
            state_in     = BK_RUN;
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_RUN;
         mode_ff       <= MODE_MANUAL;
         save_pend_ff  <= 1'b0;
         play_pend_ff  <= 1'b0;
         slot_count_ff <= '0;
         play_slot_ff  <= '0;
         pose_ff       <= '{wide_one: WIDE_CTR, wide_two: WIDE_CTR,
                            narrow_one: NARROW_CTR, narrow_two: NARROW_CTR};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         save_pend_ff  <= save_pend_in;
         play_pend_ff  <= play_pend_in;
         slot_count_ff <= slot_count_in;
         play_slot_ff  <= play_slot_in;
         pose_ff       <= pose_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   svpr_ram #(
      .WIDTH ($bits(svpr_pose_type)),
      .DEPTH (POSE_SLOTS)
   ) u_pose_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd_data.pose),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/servo_pose_record_playback_unit.sv -----
// Servo pose record/playback unit. A request beat passes through the front-end
// register, the command queue and the back end's result register; a stored pose
// load adds the pose RAM read and the BK_LOAD state. Throughput: one request per
// cycle while results are accepted, except that a pose load holds the back end in BK_LOAD. Synchronous
// active-high reset clears mode, flags, counters and queues and sets the pulses
// to center; the pose RAM is not cleared.
module servo_pose_record_playback_unit
   import svpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  svpr_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output svpr_rsp_type rsp_data
);

   logic         fq_valid;
   logic         fq_ready;
   svpr_cmd_type fq_data;
   logic         qb_valid;
   logic         qb_ready;
   svpr_cmd_type qb_data;

   svpr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd_data  (fq_data)
   );

   svpr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   svpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_played_in_playback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_status == ST_PLAYED)
      |-> (rsp_data.current_mode == MODE_PLAYBACK))
      else $error("played beat outside playback mode");

   a_save_in_manual: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.event_status == ST_SAVED) ||
                    (rsp_data.event_status == ST_FULL))
      |-> (rsp_data.current_mode == MODE_MANUAL))
      else $error("save outcome reported outside manual mode");

   a_empty_has_no_poses: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_status == ST_EMPTY)
      |-> (rsp_data.saved_count == '0))
      else $error("empty store reported with poses held");
`endif

endmodule

// ----- tb/tb_servo_pose_record_playback_unit.sv -----
// Self-checking testbench for the servo pose record/playback unit.
// Drives control-loop passes over valid/ready and predicts every result beat.
// Depends on svpr_pkg and servo_pose_record_playback_unit only.
module tb_servo_pose_record_playback_unit
   import svpr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDE_SPAN    = 2000;
   localparam int NARROW_SPAN  = 8;
   localparam int POT_FULL     = 1023;
   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_PHASE = 425;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      svpr_req_type beat;
      int           phase;
   } pass_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   svpr_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   svpr_rsp_type rsp_data;

   pass_item_type pending_passes[$];
   svpr_rsp_type  expected_pulses[$];
   int            run_phase = 0;
   int            error_count = 0;
   int            rsp_index = 0;
   int            quiet_cycles = 0;

   // Shadow state of the controller.
   logic [MODE_W-1:0] mode_q = MODE_MANUAL;
   bit                save_armed = 1'b0;
   bit                play_armed = 1'b0;
   int                stored_poses = 0;
   int                play_index = 0;
   svpr_pose_type     held_pose = '{WIDE_CTR, WIDE_CTR, NARROW_CTR, NARROW_CTR};
   svpr_pose_type     pose_mem[POSE_SLOTS];

   servo_pose_record_playback_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [WIDE_W-1:0] wide_pulse(logic [POT_W-1:0] v);
      int unsigned t;
      t = WIDE_MIN + (int'(v) * WIDE_SPAN) / POT_FULL;
      return t[WIDE_W-1:0];
   endfunction

   function automatic logic [NARROW_W-1:0] narrow_pulse(logic [POT_W-1:0] v);
      int unsigned t;
      t = NARROW_MIN + (int'(v) * NARROW_SPAN) / POT_FULL;
      return t[NARROW_W-1:0];
   endfunction

   // One loop pass: latch presses, step the mode, then run the mode's logic.
   function automatic svpr_rsp_type predict_pass(svpr_req_type r);
      svpr_rsp_type        o;
      logic [STATUS_W-1:0] status;
      status = ST_NONE;
      if (r.save_press) save_armed = 1'b1;
      if (r.play_press) play_armed = 1'b1;
      if (r.mode_press) begin
         mode_q = (mode_q == MODE_LINK) ? MODE_MANUAL : mode_q + 1'b1;
         if (mode_q == MODE_PLAYBACK) play_index = 0;
      end
      case (mode_q)
         MODE_MANUAL: begin
            held_pose.wide_one   = wide_pulse(r.pot_one);
            held_pose.wide_two   = wide_pulse(r.pot_two);
            held_pose.narrow_one = narrow_pulse(r.pot_three);
            held_pose.narrow_two = narrow_pulse(r.pot_four);
            if (save_armed) begin
               save_armed = 1'b0;
               if (stored_poses >= POSE_SLOTS) begin
                  status = ST_FULL;
               end else begin
                  pose_mem[stored_poses] = held_pose;
                  stored_poses++;
                  status = ST_SAVED;
               end
            end
         end
         MODE_PLAYBACK: begin
            if (play_armed) begin
               play_armed = 1'b0;
               if (stored_poses == 0) begin
                  status = ST_EMPTY;
               end else begin
                  if (play_index >= stored_poses) play_index = 0;
                  held_pose = pose_mem[play_index];
                  play_index++;
                  status = ST_PLAYED;
               end
            end
         end
         default: ;
      endcase
      o.pulse_one    = held_pose.wide_one;
      o.pulse_two    = held_pose.wide_two;
      o.pulse_three  = held_pose.narrow_one;
      o.pulse_four   = held_pose.narrow_two;
      o.current_mode = mode_q;
      o.event_status = status;
      o.saved_count  = stored_poses[COUNT_W-1:0];
      return o;
   endfunction

   function automatic int sender_idle_pct(int phase);
      case (phase)
         1: return 65;
         3: return 20;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(int phase);
      case (phase)
         2: return 65;
         3: return 20;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch on result %0d: %s got %0d, expected %0d", rsp_index, what, got,
                  want);
   endtask

   task automatic add_pass(int p1, int p2, int p3, int p4, bit m, bit s, bit p, int phase);
      pass_item_type item;
      item.beat.pot_one    = p1[POT_W-1:0];
      item.beat.pot_two    = p2[POT_W-1:0];
      item.beat.pot_three  = p3[POT_W-1:0];
      item.beat.pot_four   = p4[POT_W-1:0];
      item.beat.mode_press = m;
      item.beat.save_press = s;
      item.beat.play_press = p;
      item.phase           = phase;
      pending_passes.push_back(item);
   endtask

   function automatic int rand_pot();
      case ($urandom_range(9))
         0: return 0;
         1: return POT_FULL;
         default: return $urandom_range(POT_FULL);
      endcase
   endfunction

   // Driver: a new beat is offered only once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_pulses.push_back(predict_pass(req_data));
         if (!req_valid || req_ready) begin
            if (pending_passes.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(pending_passes[0].phase)) begin
               req_valid <= 1'b1;
               req_data  <= pending_passes[0].beat;
               run_phase <= pending_passes[0].phase;
               pending_passes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      svpr_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pulses.size() == 0) begin
               report_mismatch("unexpected beat, saved_count", rsp_data.saved_count, 0);
            end else begin
               want = expected_pulses.pop_front();
               if (rsp_data.pulse_one !== want.pulse_one)
                  report_mismatch("pulse_one", rsp_data.pulse_one, want.pulse_one);
               if (rsp_data.pulse_two !== want.pulse_two)
                  report_mismatch("pulse_two", rsp_data.pulse_two, want.pulse_two);
               if (rsp_data.pulse_three !== want.pulse_three)
                  report_mismatch("pulse_three", rsp_data.pulse_three, want.pulse_three);
               if (rsp_data.pulse_four !== want.pulse_four)
                  report_mismatch("pulse_four", rsp_data.pulse_four, want.pulse_four);
               if (rsp_data.current_mode !== want.current_mode)
                  report_mismatch("current_mode", rsp_data.current_mode, want.current_mode);
               if (rsp_data.event_status !== want.event_status)
                  report_mismatch("event_status", rsp_data.event_status, want.event_status);
               if (rsp_data.saved_count !== want.saved_count)
                  report_mismatch("saved_count", rsp_data.saved_count, want.saved_count);
            end
            rsp_index++;
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct(run_phase));
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      // Directed passes: extremes, empty store, held presses, playback wrap.
      add_pass(0, 0, 0, 0, 0, 0, 0, 0);
      add_pass(POT_FULL, POT_FULL, POT_FULL, POT_FULL, 0, 0, 0, 0);
      add_pass(5, 6, 7, 8, 1, 0, 1, 0);          // into playback, play with nothing stored
      add_pass(100, 200, 300, 400, 0, 1, 0, 0);  // save waits outside manual
      add_pass(1, 2, 3, 4, 1, 0, 1, 0);          // link idle, play waits
      add_pass(POT_FULL, 0, 512, 511, 1, 0, 0, 0); // back to manual, held save taken
      add_pass(0, POT_FULL, 1, 1022, 0, 1, 0, 0);
      add_pass(341, 682, 128, 896, 0, 1, 0, 0);
      add_pass(9, 9, 9, 9, 1, 0, 0, 0);          // playback, held play taken
      add_pass(0, 0, 0, 0, 0, 0, 1, 0);
      add_pass(0, 0, 0, 0, 0, 0, 1, 0);
      add_pass(0, 0, 0, 0, 0, 0, 1, 0);          // play index wraps to the first pose
      add_pass(700, 800, 900, 1000, 1, 1, 1, 0); // all three presses at once
      add_pass(1022, 1, 1023, 0, 1, 0, 0, 0);
      add_pass(512, 513, 2, 1021, 0, 1, 0, 0);
      add_pass(256, 768, 384, 640, 0, 0, 0, 0);
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < RANDOM_PHASE; i++) begin
            add_pass(rand_pot(), rand_pot(), rand_pot(), rand_pot(),
                     $urandom_range(99) < 8, $urandom_range(99) < 15,
                     $urandom_range(99) < 15, ph);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_passes.size() != 0 || req_valid || expected_pulses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_pulses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
